@@ rtl/gpt_pkg.sv @@
// Shared types, constants and saturation helper for the gravity particle table.
package gpt_pkg;

  localparam int unsigned CapacityDefault = 1024;

  // Item kinds
  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_GRAVITY_X = 2'd0;
  localparam logic [1:0] REG_GRAVITY_Y = 2'd1;
  localparam logic [1:0] REG_GRAVITY_Z = 2'd2;
  localparam logic [1:0] REG_FLOOR     = 2'd3;

  // Reset values, Q16.16
  localparam logic signed [31:0] GravityYReset = -32'sd642252;
  localparam logic signed [31:0] FloorReset    = -32'sd6553600;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        tile_id;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic signed [31:0] speed_z;
    logic [15:0]        time_step;
    logic [9:0]         entry_index;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [10:0]        live_count;
    logic [15:0]        tile_out;
    logic signed [31:0] place_x;
    logic signed [31:0] place_y;
    logic signed [31:0] place_z;
  } out_item_t;

  // One table entry as held in memory
  typedef struct packed {
    logic [15:0]        tile;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } entry_t;

  // Clamp a 34-bit signed sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    logic signed [31:0] r;
    if (x > 34'sd2147483647) r = 32'sh7FFFFFFF;
    else if (x < -34'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

@@ rtl/gravity_particle_table.sv @@
// Top level: particle table with add, tick and read items over one entry memory.
// Usage:
//   in channel (in_valid/in_ready, in_item) takes one item at a time: add, tick
//   or read. out channel (out_valid/out_ready, out_item) gives exactly one
//   result per item. cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
//   writes gravity x/y/z and the floor height; it is always ready.
// Item handling:
//   add or unused kind: result registered in the cycle after the transaction.
//   read: the READ state waits for one memory read, then registers the result.
//   tick: a dv step, then the fetch, velocity, multiply and write-back steps for
//   each particle visited (live ones plus those that fall out) through the single
//   memory port pair, and a last fetch that issues the result.
// The next item is taken once the previous result has been handed over.
// Reset clears the count, the control and the registers; memory contents are
// left as they are and are never used before being written.
// A stalled receiver simply holds the result register and blocks new items.
module gravity_particle_table #(
  parameter int unsigned CAPACITY = gpt_pkg::CapacityDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gpt_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output gpt_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import gpt_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_READ  = 7'b0000010,
    ST_DV    = 7'b0000100,
    ST_FETCH = 7'b0001000,
    ST_VEL   = 7'b0010000,
    ST_MUL   = 7'b0100000,
    ST_WB    = 7'b1000000
  } state_t;

  state_t state;
  logic signed [31:0] gravity_x, gravity_y, gravity_z, floor_height;
  logic [CW-1:0] count, idx;
  logic          moved, rd_ok, out_valid_q;
  logic [15:0]   dt_q;
  logic signed [32:0] dv_x, dv_y, dv_z;
  logic signed [48:0] pg_x, pg_y, pg_z;
  out_item_t     res_q;
  entry_t        rd_entry, wr_entry;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic signed [31:0] vnx, vny, vnz, pnx, pny, pnz;
  logic          accept, below;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == ST_IDLE) && !out_valid_q;
  assign out_valid = out_valid_q;
  assign out_item  = res_q;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_x    <= '0;
      gravity_y    <= GravityYReset;
      gravity_z    <= '0;
      floor_height <= FloorReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRAVITY_X: gravity_x    <= cfg_data;
        REG_GRAVITY_Y: gravity_y    <= cfg_data;
        REG_GRAVITY_Z: gravity_z    <= cfg_data;
        REG_FLOOR:     floor_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Memory port selection
  always_comb begin
    we       = 1'b0;
    waddr    = count[AW-1:0];
    wr_entry = '{tile: in_item.tile_id, px: in_item.start_x, py: in_item.start_y,
                 pz: in_item.start_z, vx: in_item.speed_x, vy: in_item.speed_y,
                 vz: in_item.speed_z};
    raddr    = moved ? count[AW-1:0] : idx[AW-1:0];
    if (state == ST_IDLE) begin
      raddr = AW'(in_item.entry_index);
      we    = accept && (in_item.kind == KIND_ADD) && (32'(count) < CAPACITY);
    end else if (state == ST_WB) begin
      we       = !below;
      waddr    = idx[AW-1:0];
      wr_entry = '{tile: rd_entry.tile, px: pnx, py: pny, pz: pnz,
                   vx: vnx, vy: vny, vz: vnz};
    end
  end

  gpt_ram #(.Width($bits(entry_t)), .Depth(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_entry),
    .raddr (raddr),
    .rdata (rd_entry)
  );

  // Per-axis update datapath
  gpt_axis u_ax_x (.clk(clk), .en_vel(state == ST_VEL), .en_mul(state == ST_MUL),
    .dt(dt_q), .dv(dv_x), .p(rd_entry.px), .v(rd_entry.vx), .v_new(vnx), .p_new(pnx));
  gpt_axis u_ax_y (.clk(clk), .en_vel(state == ST_VEL), .en_mul(state == ST_MUL),
    .dt(dt_q), .dv(dv_y), .p(rd_entry.py), .v(rd_entry.vy), .v_new(vny), .p_new(pny));
  gpt_axis u_ax_z (.clk(clk), .en_vel(state == ST_VEL), .en_mul(state == ST_MUL),
    .dt(dt_q), .dv(dv_z), .p(rd_entry.pz), .v(rd_entry.vz), .v_new(vnz), .p_new(pnz));

  assign below = pny < floor_height;

  // Velocity increments are the same for every particle in a tick
  assign pg_x = $signed({1'b0, dt_q}) * gravity_x;
  assign pg_y = $signed({1'b0, dt_q}) * gravity_y;
  assign pg_z = $signed({1'b0, dt_q}) * gravity_z;

  always_ff @(posedge clk) begin
    if (state == ST_DV) begin
      dv_x <= pg_x[48:16];
      dv_y <= pg_y[48:16];
      dv_z <= pg_z[48:16];
    end
    if (accept) begin
      dt_q  <= in_item.time_step;
      rd_ok <= 32'(in_item.entry_index) < 32'(count);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      idx         <= '0;
      moved       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready) out_valid_q <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_item.kind)
              KIND_ADD: begin
                out_valid_q <= 1'b1;
                if (32'(count) < CAPACITY) begin
                  count <= count + 1'b1;
                  res_q <= '{1'b1, 11'(count + 1'b1), 16'd0, 32'sd0, 32'sd0, 32'sd0};
                end else begin
                  res_q <= '{1'b0, 11'(count), 16'd0, 32'sd0, 32'sd0, 32'sd0};
                end
              end
              KIND_TICK: begin
                idx   <= '0;
                moved <= 1'b0;
                state <= ST_DV;
              end
              KIND_READ: state <= ST_READ;
              default: begin
                out_valid_q <= 1'b1;
                res_q       <= '{1'b0, 11'(count), 16'd0, 32'sd0, 32'sd0, 32'sd0};
              end
            endcase
          end
        end
        ST_READ: begin
          out_valid_q <= 1'b1;
          res_q       <= '{rd_ok, 11'(count),
                           rd_ok ? rd_entry.tile : 16'd0,
                           rd_ok ? rd_entry.px : 32'sd0,
                           rd_ok ? rd_entry.py : 32'sd0,
                           rd_ok ? rd_entry.pz : 32'sd0};
          state       <= ST_IDLE;
        end
        ST_DV: state <= ST_FETCH;
        ST_FETCH: begin
          if (idx < count) begin
            state <= ST_VEL;
          end else begin
            out_valid_q <= 1'b1;
            res_q       <= '{1'b1, 11'(count), 16'd0, 32'sd0, 32'sd0, 32'sd0};
            state       <= ST_IDLE;
          end
        end
        ST_VEL: state <= ST_MUL;
        ST_MUL: state <= ST_WB;
        ST_WB: begin
          // Survivor stays at idx; a fallen one is replaced by the last entry
          if (below) begin
            count <= count - 1'b1;
            moved <= 1'b1;
          end else begin
            idx   <= idx + 1'b1;
            moved <= 1'b0;
          end
          state <= ST_FETCH;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= CAPACITY) else $error("particle count above capacity");
  a_tick_no_grow: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> (count <= $past(count)))
    else $error("count grew during a tick or read");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WB) |-> (idx < count)) else $error("write-back beyond live entries");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready) else $error("new item taken before result issued");

endmodule

@@ rtl/gpt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/gpt_axis.sv @@
// One axis of the trapezoidal update: velocity stage, then position multiply.
module gpt_axis (
  input  logic               clk,
  input  logic               en_vel,
  input  logic               en_mul,
  input  logic [15:0]        dt,
  input  logic signed [32:0] dv,
  input  logic signed [31:0] p,
  input  logic signed [31:0] v,
  output logic signed [31:0] v_new,
  output logic signed [31:0] p_new
);
  import gpt_pkg::*;

  logic signed [31:0] p_q;
  logic signed [32:0] s_q;
  logic signed [49:0] prod_q;
  logic signed [31:0] vn;
  logic signed [32:0] dp;

  // v' = sat(v + dv), and v + v' for the position step
  assign vn = sat32({{2{v[31]}}, v} + {dv[32], dv});

  always_ff @(posedge clk) begin
    if (en_vel) begin
      v_new <= vn;
      p_q   <= p;
      s_q   <= {v[31], v} + {vn[31], vn};
    end
    if (en_mul) prod_q <= $signed({1'b0, dt}) * s_q;
  end

  // floor(prod / 2^17) is the top bits
  assign dp    = prod_q[49:17];
  assign p_new = sat32({{2{p_q[31]}}, p_q} + {dp[32], dp});

endmodule

@@ tb/tb_gravity_particle_table.sv @@
// Self-checking testbench for the gravity particle table: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_gravity_particle_table;
  import gpt_pkg::*;

  localparam int Cap = 1024;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  gravity_particle_table u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the table and registers
  logic signed [31:0] grav_x, grav_y, grav_z, floor_y;
  entry_t             shadow [Cap];
  int unsigned        shadow_count;

  out_item_t   pending_results [$];
  int          errors;
  bit          stim_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #200ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Trapezoidal step on one axis; arithmetic shift gives floor division
  function automatic void step_axis(inout logic signed [31:0] p,
                                    inout logic signed [31:0] v,
                                    input logic signed [31:0] g, input logic [15:0] dt);
    logic signed [63:0] dts, nv, sumv;
    dts  = $signed({48'd0, dt});
    nv   = 64'(clamp32(64'(v) + ((dts * 64'(g)) >>> 16)));
    sumv = 64'(v) + nv;
    p    = clamp32(64'(p) + ((dts * sumv) >>> 17));
    v    = nv[31:0];
  endfunction

  function automatic out_item_t predict_item(input in_item_t it);
    out_item_t r;
    int unsigned i;
    r = '0;
    case (it.kind)
      KIND_ADD: begin
        if (shadow_count < Cap) begin
          shadow[shadow_count] = '{it.tile_id, it.start_x, it.start_y, it.start_z,
                                   it.speed_x, it.speed_y, it.speed_z};
          shadow_count++;
          r.accepted = 1'b1;
        end
      end
      KIND_TICK: begin
        i = 0;
        while (i < shadow_count) begin
          step_axis(shadow[i].px, shadow[i].vx, grav_x, it.time_step);
          step_axis(shadow[i].py, shadow[i].vy, grav_y, it.time_step);
          step_axis(shadow[i].pz, shadow[i].vz, grav_z, it.time_step);
          if (shadow[i].py < floor_y) begin
            // swap-remove; the moved entry is revisited at the same slot
            if (i != shadow_count - 1) shadow[i] = shadow[shadow_count - 1];
            shadow_count--;
          end else begin
            i++;
          end
        end
        r.accepted = 1'b1;
      end
      KIND_READ: begin
        if (it.entry_index < shadow_count) begin
          r.accepted = 1'b1;
          r.tile_out = shadow[it.entry_index].tile;
          r.place_x  = shadow[it.entry_index].px;
          r.place_y  = shadow[it.entry_index].py;
          r.place_z  = shadow[it.entry_index].pz;
        end
      end
      default: ;
    endcase
    r.live_count = shadow_count[10:0];
    return r;
  endfunction

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input in_item_t it, input bit has_exp, input out_item_t exp_r);
    out_item_t pr;
    int n;
    n = gap_len();
    // the block is busy after each transaction
    repeat (n + 1) @(posedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    pr = predict_item(it);
    if (has_exp && pr !== exp_r) begin
      $display("%0t predictor disagrees with table row: exp %h got %h", $time, exp_r, pr);
      errors++;
    end
    pending_results.push_back(pr);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    // wait for every result to drain before touching the registers
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GRAVITY_X: grav_x  = val;
      REG_GRAVITY_Y: grav_y  = val;
      REG_GRAVITY_Z: grav_z  = val;
      default:       floor_y = val;
    endcase
  endtask

  function automatic in_item_t make_add(input logic [15:0] t,
                                        input logic signed [31:0] x, y, z, vx, vy, vz);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.kind = KIND_ADD; it.tile_id = t;
    it.start_x = x; it.start_y = y; it.start_z = z;
    it.speed_x = vx; it.speed_y = vy; it.speed_z = vz;
    return it;
  endfunction

  function automatic in_item_t make_kind(input logic [1:0] k, input logic [15:0] dt,
                                         input logic [9:0] idx);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.kind = k; it.time_step = dt; it.entry_index = idx;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
    endcase
  endfunction

  // Result side: random stalls, compare against the oldest prediction
  initial begin
    out_item_t e;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result %h", $time, out_item);
          errors++;
        end else begin
          e = pending_results.pop_front();
          if (out_item.accepted !== e.accepted)
            $display("%0t accepted exp %0d got %0d", $time, e.accepted, out_item.accepted);
          if (out_item.live_count !== e.live_count)
            $display("%0t live_count exp %0d got %0d", $time, e.live_count,
                     out_item.live_count);
          if (out_item.tile_out !== e.tile_out)
            $display("%0t tile_out exp %h got %h", $time, e.tile_out, out_item.tile_out);
          if (out_item.place_x !== e.place_x)
            $display("%0t place_x exp %h got %h", $time, e.place_x, out_item.place_x);
          if (out_item.place_y !== e.place_y)
            $display("%0t place_y exp %h got %h", $time, e.place_y, out_item.place_y);
          if (out_item.place_z !== e.place_z)
            $display("%0t place_z exp %h got %h", $time, e.place_z, out_item.place_z);
          if (out_item !== e) errors++;
        end
      end
      out_ready <= (stim_done || $urandom_range(0, 9) < 7);
    end
  end

  typedef struct {
    in_item_t  it;
    bit        has_exp;
    out_item_t exp_r;
  } dir_row_t;

  initial begin
    dir_row_t    rows [$];
    out_item_t   zero_r;
    int          sel, wait_cnt;
    grav_x = 0; grav_y = GravityYReset; grav_z = 0; floor_y = FloorReset;
    shadow_count = 0; errors = 0; stim_done = 0;
    rst = 1'b1; in_valid = 1'b0; in_item = '0;
    cfg_valid = 1'b0; cfg_index = REG_GRAVITY_X; cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    zero_r = '0;
    rows.push_back('{make_kind(KIND_READ, 0, 0), 1, zero_r});
    rows.push_back('{make_kind(KIND_TICK, 16'hFFFF, 0), 1, '{1'b1, 11'd0, 16'd0, 0, 0, 0}});
    rows.push_back('{make_kind(2'd3, 0, 0), 1, zero_r});
    rows.push_back('{make_add(16'hFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                              32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000), 1,
                     '{1'b1, 11'd1, 16'd0, 0, 0, 0}});
    rows.push_back('{make_add(16'h0000, 32'sh80000000, 0, 32'sh7FFFFFFF,
                              32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF), 1,
                     '{1'b1, 11'd2, 16'd0, 0, 0, 0}});
    rows.push_back('{make_add(16'h1234, 0, 0, 0, 0, 0, 0), 0, zero_r});
    rows.push_back('{make_kind(KIND_READ, 0, 10'd0), 1,
                     '{1'b1, 11'd3, 16'hFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000}});
    rows.push_back('{make_kind(KIND_READ, 0, 10'h3FF), 1, '{1'b0, 11'd3, 16'd0, 0, 0, 0}});
    rows.push_back('{make_kind(KIND_READ, 0, 10'd3), 1, '{1'b0, 11'd3, 16'd0, 0, 0, 0}});
    rows.push_back('{make_kind(KIND_TICK, 16'd0, 0), 0, zero_r});
    rows.push_back('{make_kind(KIND_TICK, 16'hFFFF, 0), 0, zero_r});
    rows.push_back('{make_kind(KIND_READ, 0, 10'd1), 0, zero_r});
    rows.push_back('{make_kind(KIND_TICK, 16'h8000, 0), 0, zero_r});
    rows.push_back('{make_kind(KIND_READ, 0, 10'd0), 0, zero_r});
    rows.push_back('{make_kind(2'd3, 16'hFFFF, 10'h3FF), 0, zero_r});
    foreach (rows[k]) send_item(rows[k].it, rows[k].has_exp, rows[k].exp_r);

    // Extreme gravity and floor; only the particle pinned at the top of y stays
    write_reg(REG_GRAVITY_X, 32'h7FFFFFFF);
    write_reg(REG_GRAVITY_Y, 32'h80000000);
    write_reg(REG_GRAVITY_Z, 32'h80000000);
    write_reg(REG_FLOOR, 32'h7FFFFFFF);
    send_item(make_kind(KIND_TICK, 16'hFFFF, 0), 1, '{1'b1, 11'd1, 16'd0, 0, 0, 0});

    // Random phases, each with its own register setting; table kept small
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_GRAVITY_X, $signed($urandom_range(0, 2000000)) - 1000000);
      write_reg(REG_GRAVITY_Y, (ph == 5) ? 32'h80000000 : $signed(-$urandom_range(0, 1500000)));
      write_reg(REG_GRAVITY_Z, (ph == 4) ? 32'h7FFFFFFF : $urandom);
      write_reg(REG_FLOOR, (ph == 3) ? 32'h80000000 : -$urandom_range(0, 32'h02000000));
      for (int k = 0; k < 95; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 45 && shadow_count < 40)
          send_item(make_add(16'($urandom), rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), rand_coord(), rand_coord()), 0, zero_r);
        else if (sel < 70)
          send_item(make_kind(KIND_TICK,
                              16'($urandom_range(0, 3) == 0 ? $urandom
                                                            : $urandom_range(0, 4096)),
                              10'd0), 0, zero_r);
        else if (sel < 96)
          send_item(make_kind(KIND_READ, 16'd0,
                              10'($urandom_range(0, 4) == 0 ? $urandom
                                                            : $urandom_range(0, 48))),
                    0, zero_r);
        else
          send_item(make_kind(2'd3, 16'($urandom), 10'($urandom)), 0, zero_r);
      end
    end

    // Drain
    stim_done = 1;
    wait_cnt = 0;
    while (pending_results.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/gpt_pkg.sv
rtl/gpt_ram.sv
rtl/gpt_axis.sv
rtl/gravity_particle_table.sv
tb/tb_gravity_particle_table.sv
